FILE: design/pcrf_pkg.sv
// package for the password character rule filter
// holds field widths, group bounds, register and request codes, the state type
// and the result struct; depends on nothing
package pcrf_pkg;

  // field widths
  localparam int SYM_W  = 6;
  localparam int KEY_W  = 8;
  localparam int GRP_W  = 4;
  localparam int CIDX_W = 2;
  localparam int CDAT_W = 4;

  // keymap size
  localparam int KEY_COUNT_DEF = 64;

  // key group bounds
  localparam logic [KEY_W-1:0] GROUP_BOUND_A = 8'd18;
  localparam logic [KEY_W-1:0] GROUP_BOUND_B = 8'd36;
  localparam logic [KEY_W-1:0] GROUP_BOUND_C = 8'd46;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_NO_REPEAT       = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_NO_SEQUENCE     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_REQUIRED_GROUPS = 2'd2;

  // request kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FINAL
  } state_t;

  // one result item
  typedef struct packed {
    logic [KEY_W-1:0] out_char;
    logic [SYM_W-1:0] out_symbol;
    logic             no_choice;
    logic             groups_met;
    logic             last_out;
  } res_t;

  // one-hot mask of the group a key falls in
  function automatic logic [GRP_W-1:0] group_mask(input logic [KEY_W-1:0] key);
    logic [GRP_W-1:0] m;
    if (key < GROUP_BOUND_A) begin
      m = 4'b0001;
    end else if (key < GROUP_BOUND_B) begin
      m = 4'b0010;
    end else if (key < GROUP_BOUND_C) begin
      m = 4'b0100;
    end else begin
      m = 4'b1000;
    end
    return m;
  endfunction

endpackage

FILE: design/pcrf_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read data holds while no read is enabled
module pcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pcrf_seq.sv
// sequencer: keymap read-step loop, rule registers and password history
// depends on pcrf_pkg; drives the keymap ram ports
module pcrf_seq import pcrf_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration writes
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_wdata,
  // input item
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [SYM_W-1:0]  in_key_index,
  input  logic [KEY_W-1:0]  in_key_value,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_first,
  input  logic              in_last,
  // keymap ram
  output logic              ram_we,
  output logic [SYM_W-1:0]  ram_waddr,
  output logic [KEY_W-1:0]  ram_wdata,
  output logic              ram_re,
  output logic [SYM_W-1:0]  ram_raddr,
  input  logic [KEY_W-1:0]  ram_rdata,
  // result towards the output register
  input  logic              out_free,
  output logic              res_valid,
  output res_t              res
);

  localparam int TRY_W = $clog2(KEY_COUNT);
  localparam logic [TRY_W-1:0] TRY_LAST = TRY_W'(KEY_COUNT - 1);

  state_t state, state_next;

  logic             no_repeat;
  logic             no_sequence;
  logic [GRP_W-1:0] required_groups;

  logic [SYM_W-1:0] sym;
  logic [TRY_W-1:0] tries;
  logic             step_en;
  logic             last_flag;
  logic             failed;
  logic [KEY_W-1:0] prev_key;
  logic [GRP_W-1:0] groups_left;

  logic             accept;
  logic             is_sym;
  logic             forbidden;
  logic             step;
  logic             finish;
  logic [GRP_W-1:0] groups_left_next;

  // handshake and rule check on the key just read
  assign accept    = in_valid && in_ready;
  assign is_sym    = (in_req_type == REQ_SYMBOL);
  assign forbidden = (no_repeat && (ram_rdata == prev_key)) ||
                     (no_sequence && ({1'b0, ram_rdata} == ({1'b0, prev_key} + 9'd1)));
  assign step      = (state == ST_LOOK) && step_en && forbidden;
  assign finish    = (((state == ST_LOOK) && !(step_en && forbidden)) ||
                      (state == ST_FINAL)) && out_free;
  assign groups_left_next = groups_left & ~group_mask(ram_rdata);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_sym) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (step) begin
          state_next = (tries == TRY_LAST) ? ST_FINAL : ST_LOOK;
        end else if (finish) begin
          state_next = ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == ST_IDLE);
    ram_we    = (state == ST_IDLE) && in_valid && !is_sym;
    ram_re    = ((state == ST_IDLE) && in_valid && is_sym) || step;
    ram_raddr = (state == ST_IDLE) ? in_symbol : sym + 6'd1;
    res_valid = finish;
  end

  assign ram_waddr = in_key_index;
  assign ram_wdata = in_key_value;

  // result fields
  always_comb begin
    res.out_char   = ram_rdata;
    res.out_symbol = sym;
    res.no_choice  = failed;
    res.groups_met = last_flag && (groups_left_next == '0);
    res.last_out   = last_flag;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // rule registers
  always_ff @(posedge clk) begin
    if (rst) begin
      no_repeat       <= 1'b0;
      no_sequence     <= 1'b0;
      required_groups <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NO_REPEAT:       no_repeat       <= cfg_wdata[0];
        CFG_NO_SEQUENCE:     no_sequence     <= cfg_wdata[0];
        CFG_REQUIRED_GROUPS: required_groups <= cfg_wdata[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  // password history and step loop
  always_ff @(posedge clk) begin
    if (rst) begin
      tries       <= '0;
      step_en     <= 1'b0;
      failed      <= 1'b0;
      prev_key    <= '0;
      groups_left <= '0;
    end else begin
      if (accept && is_sym) begin
        tries   <= '0;
        step_en <= !in_first && !failed && (no_repeat || no_sequence);
        if (in_first) begin
          groups_left <= required_groups;
          failed      <= 1'b0;
        end
      end
      if (step) begin
        tries <= tries + 1'b1;
        if (tries == TRY_LAST) begin
          failed <= 1'b1;
        end
      end
      if (finish) begin
        prev_key    <= ram_rdata;
        groups_left <= groups_left_next;
      end
    end
  end

  // symbol under test and last marker
  always_ff @(posedge clk) begin
    if (accept && is_sym) begin
      sym       <= in_symbol;
      last_flag <= in_last;
    end else if (step) begin
      sym <= sym + 6'd1;
    end
  end

endmodule

FILE: design/password_char_rule_filter.sv
// top level of the password character rule filter: ports, keymap ram,
// sequencer and output register; depends on pcrf_pkg, pcrf_ram, pcrf_seq
//
// Input channel s_*: tuser bit 0 is the request kind (0 load a keymap entry,
// 1 a password symbol), bit 1 marks the first symbol, tlast the last symbol.
// A load item gives no result, so loads run back to back.
// A symbol item reads its keymap entry on acceptance; when no stepping is
// needed the sequencer finishes with that entry, else it steps past each
// rejected keymap candidate, giving up with no_choice when all 64 fail. The
// result is loaded into the output register and the next item is accepted
// once the sequencer is back in idle. The step loop reads one keymap entry
// per cycle from a registered-read ram. One item is in work at a time.
// Output channel m_*: a result waits in the output register; the next input
// item is accepted as soon as the sequencer is free. When the receiver stalls
// the sequencer holds its finished result until the register frees up.
// Configuration: cfg_we/cfg_index/cfg_wdata write the rule registers.
// Reset clears the rule registers, the history and the output valid; the
// keymap is not cleared and must be loaded before use.
module password_char_rule_filter import pcrf_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CDAT_W-1:0] cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // key_index[5:0], key_value[13:6], symbol[19:14], zero
  input  logic [1:0]        s_tuser,   // req_type[0], first[1]
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // out_char[7:0], out_symbol[13:8], no_choice[14],
                                       // groups_met[15]
  output logic              m_tlast
);

  logic             ram_we;
  logic [SYM_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [SYM_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic             out_free;
  logic             res_valid;
  res_t             res;
  res_t             out_reg;

  // keymap
  pcrf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KEY_COUNT)
  ) u_keymap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // step sequencer
  pcrf_seq #(
    .KEY_COUNT (KEY_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_req_type  (s_tuser[0]),
    .in_key_index (s_tdata[5:0]),
    .in_key_value (s_tdata[13:6]),
    .in_symbol    (s_tdata[19:14]),
    .in_first     (s_tuser[1]),
    .in_last      (s_tlast),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  // output register frees when empty or being taken
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

  // pack the result item
  assign m_tdata = {out_reg.groups_met, out_reg.no_choice, out_reg.out_symbol, out_reg.out_char};
  assign m_tlast = out_reg.last_out;

endmodule
